/* hdl/wpsd_pkg.sv */
// Shared types, constants and codes for the WAV PCM stream decoder.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package wpsd_pkg;

  localparam int DEF_POSITION_BITS = 32;
  localparam int DIVISOR_W = 18;   // channels (16 b) times bytes per sample (up to 4)
  localparam int OUT_DATA_W = 216; // 211 payload bits padded to whole bytes

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_INFO   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ERR_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
  localparam logic [2:0] ERR_BAD_FIELD = 3'd4;
  localparam logic [2:0] ERR_WIDTH     = 3'd5;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_FMT    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  // Datapath to controller
  typedef struct packed {
    logic k_eq1;
    logic k_eq3;
    logic k_eq7;
    logic k_eq11;
    logic k_eq15;
    logic riff_ok;
    logic wave_ok;
    logic tag_fmt;
    logic tag_data;
    logic rem_new_nz;
    logic pcm_ok;
    logic rem_gt16;
    logic rem_is1;
    logic smp_done;
    logic err_field;
    logic err_width;
    logic dec_en;
    logic error_latched;
    logic format_seen;
    logic div_busy;
    logic div_done;
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic       step;     // byte beat accepted
    logic       proc;     // byte goes to the parser
    logic       clear;    // end of stream: reset parser state
    phase_t     phase;
    logic       err;
    logic [2:0] err_code;
    logic       smp;
    logic       info;
  } cmd_t;

endpackage
`default_nettype wire

/* hdl/wpsd_divider.sv */
// Restoring divider, one quotient bit per cycle, for the frame count.
// Depends on wpsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wpsd_divider (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [31:0]                    dividend,
  input  wire logic [wpsd_pkg::DIVISOR_W-1:0] divisor,
  output logic                                busy,
  output logic                                done,
  output logic [31:0]                         quotient
);
  import wpsd_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic [DIVISOR_W:0]   rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]   trial;

  // One shift, compare and subtract per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[DIVISOR_W-1:0], quo_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* hdl/wpsd_datapath.sv */
// Parser registers, sample assembly, result register and frame-count divider.
// Depends on wpsd_pkg and wpsd_divider; driven by commands from wpsd_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module wpsd_datapath #(
  parameter int POSITION_BITS = wpsd_pkg::DEF_POSITION_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [7:0]                        data_byte,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_wdata,
  input  wire wpsd_pkg::cmd_t                    cmd,
  output wpsd_pkg::status_t                      st,
  output logic [1:0]                             res_kind,
  output logic [wpsd_pkg::OUT_DATA_W-1:0]        res_data
);
  import wpsd_pkg::*;

  logic                     dec_en_r, dec_en_nxt;
  logic [3:0]               k_r, k_nxt;
  logic [31:0]              tag_r, tag_nxt;
  logic [31:0]              rem_r, rem_nxt;
  logic [15:0]              ch_r, ch_nxt;
  logic [31:0]              rate_r, rate_nxt;
  logic [15:0]              bits_r, bits_nxt;
  logic                     fmt_seen_r, fmt_seen_nxt;
  logic [31:0]              asm_r, asm_nxt;
  logic [1:0]               idx_r, idx_nxt;
  logic [15:0]              cc_r, cc_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     err_r, err_nxt;

  logic [1:0]               o_kind_r, o_kind_nxt;
  logic [31:0]              o_smp_r, o_smp_nxt;
  logic [15:0]              o_cidx_r, o_cidx_nxt;
  logic [15:0]              o_ch_r, o_ch_nxt;
  logic [31:0]              o_rate_r, o_rate_nxt;
  logic [15:0]              o_bits_r, o_bits_nxt;
  logic [31:0]              o_off_r, o_off_nxt;
  logic [31:0]              o_size_r, o_size_nxt;
  logic [31:0]              o_frm_r, o_frm_nxt;
  logic [2:0]               o_err_r, o_err_nxt;

  logic [31:0]              tag_shift;
  logic [31:0]              rem_new;
  logic [31:0]              full;
  logic [31:0]              conv;
  logic [2:0]               bytes;
  logic [16:0]              cc_inc;
  logic [63:0]              pos_ext;
  logic [DIVISOR_W-1:0]     divisor;
  logic                     div_busy, div_done;
  logic [31:0]              quotient;

  assign tag_shift = {tag_r[23:0], data_byte};
  assign rem_new   = {data_byte, rem_r[23:0]};
  assign bytes     = bits_r[5:3];
  assign full      = asm_r | (32'(data_byte) << {idx_r, 3'b000});
  assign cc_inc    = {1'b0, cc_r} + 17'd1;
  assign pos_ext   = 64'(pos_r + POSITION_BITS'(1));

  // Convert the assembled word to Q1.31
  always_comb begin
    case (bytes)
      3'd1:    conv = {full[7:0] ^ 8'h80, 24'h0};
      3'd2:    conv = {full[15:0], 16'h0};
      3'd3:    conv = {full[23:0], 8'h0};
      default: conv = full;
    endcase
  end

  // Bytes per frame as the divisor
  always_comb begin
    case (bytes)
      3'd1:    divisor = DIVISOR_W'(ch_r);
      3'd2:    divisor = DIVISOR_W'({ch_r, 1'b0});
      3'd3:    divisor = DIVISOR_W'(ch_r) + DIVISOR_W'({ch_r, 1'b0});
      default: divisor = DIVISOR_W'({ch_r, 2'b00});
    endcase
  end

  // Status for the controller
  always_comb begin
    st.k_eq1         = (k_r == 4'd1);
    st.k_eq3         = (k_r == 4'd3);
    st.k_eq7         = (k_r == 4'd7);
    st.k_eq11        = (k_r == 4'd11);
    st.k_eq15        = (k_r == 4'd15);
    st.riff_ok       = (tag_shift == TAG_RIFF);
    st.wave_ok       = (tag_shift == TAG_WAVE);
    st.tag_fmt       = (tag_r == TAG_FMT);
    st.tag_data      = (tag_r == TAG_DATA);
    st.rem_new_nz    = (rem_new != 32'd0);
    st.pcm_ok        = ({data_byte, asm_r[7:0]} == 16'd1);
    st.rem_gt16      = (rem_r > 32'd16);
    st.rem_is1       = (rem_r == 32'd1);
    st.smp_done      = ({1'b0, idx_r} + 3'd1 == bytes);
    st.err_field     = !fmt_seen_r || (ch_r == 16'd0) || (rate_r == 32'd0)
                       || (bits_r == 16'd0);
    st.err_width     = (bits_r != 16'd8) && (bits_r != 16'd16) && (bits_r != 16'd24)
                       && (bits_r != 16'd32);
    st.dec_en        = dec_en_r;
    st.error_latched = err_r;
    st.format_seen   = fmt_seen_r;
    st.div_busy      = div_busy | div_done;
    st.div_done      = div_done;
  end

  // Parser register updates per phase
  always_comb begin
    dec_en_nxt   = cfg_we ? cfg_wdata : dec_en_r;
    k_nxt        = k_r;
    tag_nxt      = tag_r;
    rem_nxt      = rem_r;
    ch_nxt       = ch_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    fmt_seen_nxt = fmt_seen_r;
    asm_nxt      = asm_r;
    idx_nxt      = idx_r;
    cc_nxt       = cc_r;
    pos_nxt      = cmd.step ? pos_r + POSITION_BITS'(1) : pos_r;
    err_nxt      = err_r | cmd.err;
    if (cmd.proc) begin
      case (cmd.phase)
        PH_HEADER: begin
          tag_nxt = tag_shift;
          k_nxt   = (k_r == 4'd11) ? 4'd0 : k_r + 4'd1;
        end
        PH_CHUNK: begin
          if (k_r < 4'd4) tag_nxt = tag_shift;
          case (k_r)
            4'd4:    rem_nxt = {24'h0, data_byte};
            4'd5:    rem_nxt = {rem_r[31:16], data_byte, rem_r[7:0]};
            4'd6:    rem_nxt = {rem_r[31:24], data_byte, rem_r[15:0]};
            4'd7:    rem_nxt = rem_new;
            default: rem_nxt = rem_r;
          endcase
          k_nxt = (k_r == 4'd7) ? 4'd0 : k_r + 4'd1;
        end
        PH_FMT: begin
          case (k_r)
            4'd0:    asm_nxt = {24'h0, data_byte};
            4'd1:    asm_nxt = '0;
            4'd2:    ch_nxt = {8'h0, data_byte};
            4'd3:    ch_nxt = {data_byte, ch_r[7:0]};
            4'd4:    rate_nxt = {24'h0, data_byte};
            4'd5:    rate_nxt = {rate_r[31:16], data_byte, rate_r[7:0]};
            4'd6:    rate_nxt = {rate_r[31:24], data_byte, rate_r[15:0]};
            4'd7:    rate_nxt = {data_byte, rate_r[23:0]};
            4'd14:   bits_nxt = {8'h0, data_byte};
            4'd15:   bits_nxt = {data_byte, bits_r[7:0]};
            default: asm_nxt = asm_r;
          endcase
          if (k_r == 4'd15) begin
            fmt_seen_nxt = 1'b1;
            if (rem_r > 32'd16) rem_nxt = (rem_r - 32'd15) & ~32'd1;
          end
          k_nxt = k_r + 4'd1;
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 32'd1;
        end
        PH_DATA: begin
          rem_nxt = rem_r - 32'd1;
          if (st.smp_done) begin
            asm_nxt = '0;
            idx_nxt = '0;
            cc_nxt  = (cc_inc >= {1'b0, ch_r}) ? 16'd0 : cc_inc[15:0];
          end else begin
            asm_nxt = full;
            idx_nxt = idx_r + 2'd1;
          end
        end
        default: k_nxt = k_r;
      endcase
    end
    // Data chunk header opens a new sample run
    if (cmd.info) begin
      asm_nxt = '0;
      idx_nxt = '0;
      cc_nxt  = '0;
    end
    // End of stream drops all parser state
    if (cmd.clear) begin
      k_nxt        = '0;
      tag_nxt      = '0;
      rem_nxt      = '0;
      ch_nxt       = '0;
      rate_nxt     = '0;
      bits_nxt     = '0;
      fmt_seen_nxt = 1'b0;
      asm_nxt      = '0;
      idx_nxt      = '0;
      cc_nxt       = '0;
      pos_nxt      = '0;
      err_nxt      = 1'b0;
    end
  end

  // Result register loads
  always_comb begin
    o_kind_nxt = o_kind_r;
    o_smp_nxt  = o_smp_r;
    o_cidx_nxt = o_cidx_r;
    o_ch_nxt   = o_ch_r;
    o_rate_nxt = o_rate_r;
    o_bits_nxt = o_bits_r;
    o_off_nxt  = o_off_r;
    o_size_nxt = o_size_r;
    o_frm_nxt  = o_frm_r;
    o_err_nxt  = o_err_r;
    if (cmd.err || cmd.smp || cmd.info) begin
      o_kind_nxt = KIND_SAMPLE;
      o_smp_nxt  = '0;
      o_cidx_nxt = '0;
      o_ch_nxt   = '0;
      o_rate_nxt = '0;
      o_bits_nxt = '0;
      o_off_nxt  = '0;
      o_size_nxt = '0;
      o_frm_nxt  = '0;
      o_err_nxt  = ERR_NONE;
      if (cmd.err) begin
        o_kind_nxt = KIND_ERROR;
        o_err_nxt  = cmd.err_code;
      end else if (cmd.smp) begin
        o_smp_nxt  = conv;
        o_cidx_nxt = cc_r;
      end else begin
        o_kind_nxt = KIND_INFO;
        o_ch_nxt   = ch_r;
        o_rate_nxt = rate_r;
        o_bits_nxt = bits_r;
        o_off_nxt  = pos_ext[31:0];
        o_size_nxt = rem_new;
      end
    end
    if (div_done) o_frm_nxt = quotient;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_en_r   <= 1'b1;
      k_r        <= '0;
      tag_r      <= '0;
      rem_r      <= '0;
      ch_r       <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      fmt_seen_r <= 1'b0;
      asm_r      <= '0;
      idx_r      <= '0;
      cc_r       <= '0;
      pos_r      <= '0;
      err_r      <= 1'b0;
    end else begin
      dec_en_r   <= dec_en_nxt;
      k_r        <= k_nxt;
      tag_r      <= tag_nxt;
      rem_r      <= rem_nxt;
      ch_r       <= ch_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      asm_r      <= asm_nxt;
      idx_r      <= idx_nxt;
      cc_r       <= cc_nxt;
      pos_r      <= pos_nxt;
      err_r      <= err_nxt;
    end
    o_kind_r <= o_kind_nxt;
    o_smp_r  <= o_smp_nxt;
    o_cidx_r <= o_cidx_nxt;
    o_ch_r   <= o_ch_nxt;
    o_rate_r <= o_rate_nxt;
    o_bits_r <= o_bits_nxt;
    o_off_r  <= o_off_nxt;
    o_size_r <= o_size_nxt;
    o_frm_r  <= o_frm_nxt;
    o_err_r  <= o_err_nxt;
  end

  wpsd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.info),
    .dividend (rem_new),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  assign res_kind = o_kind_r;
  assign res_data = {5'b0, o_err_r, o_frm_r, o_size_r, o_off_r, o_bits_r, o_rate_r,
                     o_ch_r, o_cidx_r, o_smp_r};

endmodule
`default_nettype wire

/* hdl/wpsd_ctrl.sv */
// Parse-phase state machine and stream handshake control.
// Depends on wpsd_pkg; drives wpsd_datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module wpsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tlast,
  input  wire logic              out_tready,
  input  wire wpsd_pkg::status_t st,
  output logic                   in_tready,
  output logic                   out_tvalid,
  output wpsd_pkg::cmd_t         cmd
);
  import wpsd_pkg::*;

  phase_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   step;

  assign in_tready  = !st.div_busy && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign step       = in_tvalid && in_tready;

  // Next phase and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd.step     = step;
    cmd.proc     = step && !st.error_latched;
    cmd.clear    = step && in_tlast;
    cmd.phase    = state_r;
    cmd.err      = 1'b0;
    cmd.err_code = ERR_NONE;
    cmd.smp      = 1'b0;
    cmd.info     = 1'b0;
    if (cmd.proc) begin
      case (state_r)
        PH_HEADER: begin
          if (st.k_eq3 && !st.riff_ok) begin
            cmd.err      = 1'b1;
            cmd.err_code = ERR_NOT_RIFF;
          end else if (st.k_eq11) begin
            if (!st.wave_ok) begin
              cmd.err      = 1'b1;
              cmd.err_code = ERR_NOT_WAVE;
            end else begin
              state_nxt = PH_CHUNK;
            end
          end
        end
        PH_CHUNK: begin
          if (st.k_eq7) begin
            if (st.tag_fmt) begin
              state_nxt = PH_FMT;
            end else if (st.tag_data) begin
              if (st.err_field) begin
                cmd.err      = 1'b1;
                cmd.err_code = ERR_BAD_FIELD;
              end else if (st.err_width) begin
                cmd.err      = 1'b1;
                cmd.err_code = ERR_WIDTH;
              end else begin
                cmd.info  = 1'b1;
                state_nxt = st.rem_new_nz ? PH_DATA : PH_CHUNK;
              end
            end else begin
              state_nxt = st.rem_new_nz ? PH_SKIP : PH_CHUNK;
            end
          end
        end
        PH_FMT: begin
          if (st.k_eq1 && !st.pcm_ok) begin
            cmd.err      = 1'b1;
            cmd.err_code = ERR_NOT_PCM;
          end else if (st.k_eq15) begin
            state_nxt = st.rem_gt16 ? PH_SKIP : PH_CHUNK;
          end
        end
        PH_SKIP: begin
          if (st.rem_is1) state_nxt = PH_CHUNK;
        end
        PH_DATA: begin
          cmd.smp = st.smp_done && st.dec_en;
          if (st.rem_is1) state_nxt = PH_CHUNK;
        end
        default: state_nxt = PH_HEADER;
      endcase
    end
    if (cmd.clear) state_nxt = PH_HEADER;
  end

  // Result slot: drain on take, fill on any load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.err || cmd.smp || st.div_done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_HEADER;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_info_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> !out_valid_r)
    else $error("frame count finished while result slot occupied");

  a_error_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.err |-> !st.error_latched)
    else $error("error raised twice without end of stream");

  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> state_r == PH_HEADER)
    else $error("parser did not restart after end of stream");

  a_data_needs_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == PH_DATA |-> st.format_seen)
    else $error("data phase without fmt chunk");

endmodule
`default_nettype wire

/* hdl/wav_pcm_stream_decoder_top.sv */
// WAV PCM stream decoder top level: controller plus datapath.
// Depends on wpsd_pkg, wpsd_ctrl and wpsd_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes a RIFF/WAVE file one byte per beat on the in_ channel and returns
// results on the out_ channel: an error, one format-info result per data
// chunk header, and Q1.31 samples while cfg decode enable is 1. Bytes are
// taken at one per cycle unless the input is held off. The byte that
// completes a valid data chunk header stalls the input while the serial
// divider works out the frame count one quotient bit per cycle. A byte is
// taken only while the output register is empty or its result is taken in
// the same cycle, so a result that waits on out_tready holds off the input.
// in_tlast marks the last byte of a file and restarts the parser after it;
// the decode enable setting is kept.
module wav_pcm_stream_decoder_top #(
  parameter int POSITION_BITS = wpsd_pkg::DEF_POSITION_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,  // [7:0] data_byte
  input  wire logic                               in_tlast,  // end_of_stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [31:0] sample_value, [47:32] channel_index, [63:48] channels per frame,
  // [95:64] sample_rate, [111:96] sample_bits, [143:112] data start position,
  // [175:144] data_size, [207:176] frames in chunk, [210:208] error_code
  output logic [wpsd_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [1:0]                              out_tuser, // [1:0] result_kind
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_wdata  // decode_enable
);
  import wpsd_pkg::*;

  status_t st;
  cmd_t    cmd;

  wpsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .st         (st),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  wpsd_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .res_kind  (out_tuser),
    .res_data  (out_tdata)
  );

endmodule
`default_nettype wire

/* tb/sv/wpsd_checker.sv */
// Result checker for the WAV PCM stream decoder: mirrors the parser on every
// accepted input beat and compares each output beat. Depends on wpsd_pkg.
`timescale 1ns / 1ps
module wpsd_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic [7:0]                    in_tdata,
  input  wire logic                          in_tlast,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [wpsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic [1:0]                    out_tuser,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);
  import wpsd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample;
    logic [15:0] chan;
    logic [15:0] chan_cnt;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] frames;
    logic [2:0]  err;
  } wav_result_t;

  wav_result_t expected_results[$];

  // Mirrored parser state
  phase_t      phase;
  logic [31:0] hdr_cnt;
  logic [31:0] tag_sr;
  logic [31:0] remaining;
  logic [15:0] fmt_channels;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic        fmt_seen;
  logic [31:0] assembly;
  logic [1:0]  byte_idx;
  logic [15:0] chan_ctr;
  logic [31:0] position;
  logic        err_latched;
  logic        decode_on;

  // Per-beat prediction scratch
  wav_result_t next_res;
  logic        has_res;

  assign pending = expected_results.size();

  task automatic clear_parser();
    phase = PH_HEADER;
    hdr_cnt = '0; tag_sr = '0; remaining = '0;
    fmt_channels = '0; fmt_rate = '0; fmt_bits = '0; fmt_seen = 1'b0;
    assembly = '0; byte_idx = '0; chan_ctr = '0;
    position = '0; err_latched = 1'b0;
  endtask

  task automatic flag_error(input logic [2:0] code);
    err_latched = 1'b1;
    next_res.kind = KIND_ERROR;
    next_res.err = code;
    has_res = 1'b1;
  endtask

  // Data chunk header complete: validate the format, emit the info beat
  task automatic open_data_chunk();
    logic [31:0] bytes_per;
    if (!fmt_seen) begin
      flag_error(ERR_BAD_FIELD);
    end else if (fmt_channels == 0 || fmt_rate == 0 || fmt_bits == 0) begin
      flag_error(ERR_BAD_FIELD);
    end else if (fmt_bits != 8 && fmt_bits != 16 && fmt_bits != 24 && fmt_bits != 32) begin
      flag_error(ERR_WIDTH);
    end else begin
      bytes_per = fmt_bits / 8;
      next_res.kind = KIND_INFO;
      next_res.chan_cnt = fmt_channels;
      next_res.rate = fmt_rate;
      next_res.bits = fmt_bits;
      next_res.offset = position;
      next_res.size = remaining;
      next_res.frames = (remaining / bytes_per) / {16'd0, fmt_channels};
      has_res = 1'b1;
      assembly = '0; byte_idx = '0; chan_ctr = '0;
      phase = (remaining != 0) ? PH_DATA : PH_CHUNK;
    end
  endtask

  task automatic take_data_byte(input logic [7:0] b);
    logic [31:0] bytes_per;
    logic [31:0] val;
    bytes_per = fmt_bits / 8;
    remaining = remaining - 1;
    assembly = assembly | ({24'd0, b} << (8 * byte_idx));
    if ({30'd0, byte_idx} + 1 >= bytes_per) begin
      case (fmt_bits)
        16'd8:   val = {assembly[7:0] ^ 8'h80, 24'd0};
        16'd16:  val = {assembly[15:0], 16'd0};
        16'd24:  val = {assembly[23:0], 8'd0};
        default: val = assembly;
      endcase
      if (decode_on) begin
        next_res.kind = KIND_SAMPLE;
        next_res.sample = val;
        next_res.chan = chan_ctr;
        has_res = 1'b1;
      end
      assembly = '0;
      byte_idx = '0;
      chan_ctr = ({16'd0, chan_ctr} + 1 >= {16'd0, fmt_channels}) ? 16'd0
                                                                 : chan_ctr + 16'd1;
    end else begin
      byte_idx = byte_idx + 2'd1;
    end
    if (remaining == 0) begin
      phase = PH_CHUNK;
      hdr_cnt = '0;
    end
  endtask

  // Advance the mirrored parser by one byte beat
  task automatic predict_wav_byte(input logic [7:0] b, input logic last);
    next_res = '0;
    has_res = 1'b0;
    position = position + 1;
    if (!err_latched) begin
      case (phase)
        PH_HEADER: begin
          tag_sr = {tag_sr[23:0], b};
          if (hdr_cnt == 3 && tag_sr != TAG_RIFF) begin
            flag_error(ERR_NOT_RIFF);
          end else if (hdr_cnt == 11) begin
            if (tag_sr != TAG_WAVE) begin
              flag_error(ERR_NOT_WAVE);
            end else begin
              phase = PH_CHUNK;
              hdr_cnt = '0;
            end
          end else begin
            hdr_cnt = hdr_cnt + 1;
          end
        end
        PH_CHUNK: begin
          if (hdr_cnt == 0) remaining = '0;
          if (hdr_cnt < 4) tag_sr = {tag_sr[23:0], b};
          else remaining = remaining | ({24'd0, b} << (8 * hdr_cnt[1:0]));
          hdr_cnt = hdr_cnt + 1;
          if (hdr_cnt == 8) begin
            hdr_cnt = '0;
            if (tag_sr == TAG_FMT) phase = PH_FMT;
            else if (tag_sr == TAG_DATA) open_data_chunk();
            else phase = (remaining != 0) ? PH_SKIP : PH_CHUNK;
          end
        end
        PH_FMT: begin
          case (hdr_cnt)
            0: assembly = {24'd0, b};
            1: begin
              assembly = assembly | {16'd0, b, 8'd0};
              if (assembly != 1) flag_error(ERR_NOT_PCM);
              else assembly = '0;
            end
            2: fmt_channels = {8'd0, b};
            3: fmt_channels[15:8] = b;
            4: fmt_rate = {24'd0, b};
            5: fmt_rate[15:8] = b;
            6: fmt_rate[23:16] = b;
            7: fmt_rate[31:24] = b;
            14: fmt_bits = {8'd0, b};
            15: fmt_bits[15:8] = b;
            default: ;
          endcase
          if (!err_latched) begin
            hdr_cnt = hdr_cnt + 1;
            if (hdr_cnt == 16) begin
              hdr_cnt = '0;
              fmt_seen = 1'b1;
              if (remaining > 16) begin
                remaining = ((remaining - 16) + 1) & ~32'd1;
                phase = PH_SKIP;
              end else begin
                phase = PH_CHUNK;
              end
            end
          end
        end
        PH_SKIP: begin
          remaining = remaining - 1;
          if (remaining == 0) begin
            phase = PH_CHUNK;
            hdr_cnt = '0;
          end
        end
        PH_DATA: take_data_byte(b);
        default: ;
      endcase
    end
    if (has_res) expected_results.push_back(next_res);
    if (last) clear_parser();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %0s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compare one output beat with the oldest expectation
  task automatic check_result_beat();
    wav_result_t want;
    wav_result_t seen;
    seen.kind = out_tuser;
    seen.sample = out_tdata[31:0];
    seen.chan = out_tdata[47:32];
    seen.chan_cnt = out_tdata[63:48];
    seen.rate = out_tdata[95:64];
    seen.bits = out_tdata[111:96];
    seen.offset = out_tdata[143:112];
    seen.size = out_tdata[175:144];
    seen.frames = out_tdata[207:176];
    seen.err = out_tdata[210:208];
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result kind", {30'd0, seen.kind}, 32'd0);
    end else begin
      want = expected_results.pop_front();
      if (seen.kind != want.kind)
        report_mismatch("result_kind", 32'(seen.kind), 32'(want.kind));
      if (seen.sample != want.sample) report_mismatch("sample_value", seen.sample, want.sample);
      if (seen.chan != want.chan)
        report_mismatch("channel_index", 32'(seen.chan), 32'(want.chan));
      if (seen.chan_cnt != want.chan_cnt)
        report_mismatch("chan_total", 32'(seen.chan_cnt), 32'(want.chan_cnt));
      if (seen.rate != want.rate) report_mismatch("sample_rate", seen.rate, want.rate);
      if (seen.bits != want.bits)
        report_mismatch("sample_bits", 32'(seen.bits), 32'(want.bits));
      if (seen.offset != want.offset) report_mismatch("data_start", seen.offset, want.offset);
      if (seen.size != want.size) report_mismatch("data_size", seen.size, want.size);
      if (seen.frames != want.frames) report_mismatch("frame_total", seen.frames, want.frames);
      if (seen.err != want.err)
        report_mismatch("error_code", 32'(seen.err), 32'(want.err));
    end
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      decode_on = 1'b1;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result_beat();
      if (in_tvalid && in_tready) predict_wav_byte(in_tdata, in_tlast);
      if (cfg_we) decode_on = cfg_wdata;
    end
  end

endmodule

/* tb/sv/wav_pcm_stream_decoder_top_tb.sv */
// Testbench top for the WAV PCM stream decoder: builds WAV files, streams
// them byte by byte, idles both sides. Depends on wpsd_pkg and wpsd_checker.
`timescale 1ns / 1ps
module wav_pcm_stream_decoder_top_tb;
  import wpsd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int fail_count;
  int pending;

  logic [7:0] wav_bytes[$];
  bit burst_mode;
  bit stall_req;
  int bytes_sent;

  wav_pcm_stream_decoder_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  wpsd_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short idle gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // Receiver: random ready pattern, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (stall_req) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        stall_req = 1'b0;
      end
      @(negedge clk) out_tready <= 1'b1;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      n = burst_mode ? 0 : pick_gap();
      if (n > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic push16(input logic [15:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
  endtask

  task automatic push32(input logic [31:0] v);
    push16(v[15:0]);
    push16(v[31:16]);
  endtask

  task automatic push_tag(input logic [31:0] t);
    wav_bytes.push_back(t[31:24]);
    wav_bytes.push_back(t[23:16]);
    wav_bytes.push_back(t[15:8]);
    wav_bytes.push_back(t[7:0]);
  endtask

  // Assemble one file into wav_bytes
  task automatic build_wav(input int bits, input int chans, input logic [31:0] rate,
                           input int fmt_size, input int fmt_tag, input int nframes,
                           input int partial, input int junk_len, input int ndata,
                           input bit data_first);
    int extra;
    int dsize;
    wav_bytes.delete();
    push_tag(TAG_RIFF);
    push32($urandom);
    push_tag(TAG_WAVE);
    if (data_first) begin
      push_tag(TAG_DATA);
      push32(32'd4);
      repeat (4) wav_bytes.push_back(8'($urandom));
    end
    push_tag(TAG_FMT);
    push32(32'(fmt_size));
    push16(16'(fmt_tag));
    push16(16'(chans));
    push32(rate);
    push32($urandom);
    push16(16'($urandom));
    push16(16'(bits));
    extra = (fmt_size > 16) ? ((fmt_size - 16 + 1) & ~1) : 0;
    repeat (extra) wav_bytes.push_back(8'($urandom));
    if (junk_len >= 0) begin
      push_tag(32'h4C495354);
      push32(32'(junk_len));
      repeat (junk_len) wav_bytes.push_back(8'($urandom));
    end
    dsize = nframes * ((chans < 1) ? 1 : (chans > 4) ? 4 : chans)
            * ((bits / 8 < 1) ? 1 : bits / 8) + partial;
    repeat (ndata) begin
      push_tag(TAG_DATA);
      push32(32'(dsize));
      repeat (dsize) wav_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int n;
    n = burst_mode ? 0 : pick_gap();
    repeat (n) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_wav();
    foreach (wav_bytes[i]) send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
  endtask

  // Write the register only once the block has drained
  task automatic set_decode(input logic v);
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic random_wav();
    int r, bits, chans, fmt_size, fmt_tag, bpers, partial;
    logic [31:0] rate;
    r = $urandom_range(0, 99);
    bits = (r < 22) ? 8 : (r < 44) ? 16 : (r < 66) ? 24 : (r < 90) ? 32 :
           (r < 93) ? 0 : (r < 96) ? 12 : $urandom_range(1, 65535);
    r = $urandom_range(0, 99);
    chans = (r < 92) ? $urandom_range(1, 3) : (r < 95) ? 0 : (r < 97) ? 65535 :
            $urandom_range(1, 65535);
    rate = ($urandom_range(0, 29) == 0) ? 32'd0 : $urandom;
    fmt_size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 16;
    fmt_tag = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 65535) : 1;
    bpers = (bits / 8 < 1) ? 1 : bits / 8;
    partial = ($urandom_range(0, 4) == 0) ? $urandom_range(0, bpers - 1) : 0;
    build_wav(bits, chans, rate, fmt_size, fmt_tag, $urandom_range(0, 6), partial,
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1,
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 1,
              $urandom_range(0, 24) == 0);
    r = $urandom_range(0, 99);
    // Noise: flip a byte, cut the file short, or send plain garbage
    if (r < 8) begin
      wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom);
    end else if (r < 13) begin
      wav_bytes = wav_bytes[0:$urandom_range(0, wav_bytes.size() - 1)];
    end else if (r < 16) begin
      wav_bytes.delete();
      repeat ($urandom_range(10, 30)) wav_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    bytes_sent = 0;
    burst_mode = 1'b0;
    stall_req = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    set_decode(1'b1);

    // Directed: every width, format errors, chunk layouts
    build_wav(8, 1, 32'd8000, 16, 1, 4, 0, -1, 1, 0); send_wav();
    build_wav(16, 2, 32'd44100, 16, 1, 3, 0, -1, 1, 0); send_wav();
    build_wav(24, 1, 32'd48000, 16, 1, 3, 0, -1, 1, 0); send_wav();
    build_wav(32, 2, 32'hFFFFFFFF, 16, 1, 2, 0, -1, 1, 0); send_wav();
    // Error files are cut short; all but the first end right after the byte that raises the error
    build_wav(8, 1, 32'd8000, 16, 1, 1, 0, -1, 1, 0); wav_bytes[0] = 8'h00;
    wav_bytes = wav_bytes[0:7]; send_wav();
    build_wav(8, 1, 32'd8000, 16, 1, 1, 0, -1, 1, 0); wav_bytes[8] = 8'hFF;
    wav_bytes = wav_bytes[0:11]; send_wav();
    build_wav(16, 1, 32'd8000, 16, 3, 1, 0, -1, 1, 0);
    wav_bytes = wav_bytes[0:21]; send_wav();
    build_wav(16, 0, 32'd8000, 16, 1, 1, 0, -1, 1, 0);
    wav_bytes = wav_bytes[0:43]; send_wav();
    build_wav(12, 1, 32'd8000, 16, 1, 1, 0, -1, 1, 0);
    wav_bytes = wav_bytes[0:43]; send_wav();
    build_wav(16, 1, 32'd8000, 16, 1, 1, 0, -1, 1, 1);
    wav_bytes = wav_bytes[0:19]; send_wav();
    build_wav(16, 1, 32'd8000, 19, 1, 2, 0, 3, 1, 0); send_wav();
    build_wav(16, 1, 32'd8000, 14, 1, 2, 0, 0, 1, 0); send_wav();
    build_wav(24, 3, 32'd96000, 20, 1, 1, 2, -1, 2, 0); send_wav();
    build_wav(16, 65535, 32'd1, 16, 1, 0, 0, -1, 1, 0); send_wav();
    build_wav(32, 1, 32'd8000, 16, 1, 0, 0, -1, 0, 0); send_wav();
    build_wav(8, 2, 32'd8000, 16, 1, 8, 0, -1, 1, 0);
    // Hold the receiver off while the sender keeps offering bytes
    stall_req = 1'b1;
    send_wav();
    set_decode(1'b0);
    build_wav(16, 2, 32'd22050, 16, 1, 3, 1, -1, 1, 0); send_wav();
    set_decode(1'b1);

    // Random files, mostly well formed
    while (bytes_sent < 650) begin
      if ($urandom_range(0, 7) == 0) set_decode($urandom_range(0, 4) != 0);
      burst_mode = ($urandom_range(0, 4) == 0);
      random_wav();
      send_wav();
    end
    burst_mode = 1'b0;

    @(negedge clk) in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
